@@ rtl/core/tty_receive_line_discipline_defines.svh @@
// Assertion macros used by the front part of the receive line discipline.
`ifndef TTY_RECEIVE_LINE_DISCIPLINE_DEFINES_SVH
`define TTY_RECEIVE_LINE_DISCIPLINE_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define TTYRLD_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked outside reset.
`define TTYRLD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

@@ rtl/core/ttyrld_pkg.sv @@
// Types and constants of the receive line discipline.
package ttyrld_pkg;

  localparam logic [1:0] ACT_RECV  = 2'd0;
  localparam logic [1:0] ACT_POP   = 2'd1;
  localparam logic [1:0] ACT_FLUSH = 2'd2;
  localparam logic [1:0] ACT_NOP   = 2'd3;

  localparam logic [1:0] EV_NONE  = 2'd0;
  localparam logic [1:0] EV_ABORT = 2'd1;
  localparam logic [1:0] EV_TRAP  = 2'd2;

  localparam logic [1:0] FLOW_NONE = 2'd0;
  localparam logic [1:0] FLOW_XOFF = 2'd1;
  localparam logic [1:0] FLOW_XON  = 2'd2;

  localparam logic [2:0] REG_OPTION = 3'd0;
  localparam logic [2:0] REG_ABORT  = 3'd1;
  localparam logic [2:0] REG_ERASE  = 3'd2;
  localparam logic [2:0] REG_KILL   = 3'd3;
  localparam logic [2:0] REG_EOF    = 3'd4;
  localparam logic [2:0] REG_TRAP   = 3'd5;
  localparam logic [2:0] REG_STOP   = 3'd6;
  localparam logic [2:0] REG_RESUME = 3'd7;

  localparam int OB_LINE    = 0;
  localparam int OB_ECHO    = 1;
  localparam int OB_CRMAP   = 2;
  localparam int OB_FLOW    = 3;
  localparam int OB_SEVEN   = 4;
  localparam int OB_BREAK   = 5;
  localparam int OB_MONTRAP = 6;

  localparam logic [7:0] CH_XON   = 8'h11;
  localparam logic [7:0] CH_XOFF  = 8'h13;
  localparam logic [7:0] CH_CR    = 8'h0d;
  localparam logic [7:0] CH_LF    = 8'h0a;
  localparam logic [7:0] CH_BS    = 8'h08;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_CARET = 8'h5e;
  localparam logic [7:0] CH_AT    = 8'h40;
  localparam logic [7:0] MASK7    = 8'h7f;
  localparam logic [7:0] LINE_MAX = 8'hff;

  // Queue between the front and the back part.
  localparam int Q_DEPTH = 4;
  localparam int Q_AW    = 2;
  localparam int Q_CW    = 3;

  // One classified input item, expanded by the back part into 1 to 3 results.
  typedef struct packed {
    logic [2:0][7:0] echo;
    logic [1:0]      necho;
    logic [1:0]      event_res;
    logic            overflow;
    logic [1:0]      flow_request;
    logic            remote_stopped;
    logic            data_ready;
    logic [7:0]      read_data;
    logic            read_valid;
    logic [9:0]      fill_level;
  } job_t;

endpackage

@@ rtl/core/ttyrld_if.sv @@
// Channel interfaces of the receive line discipline.
interface ttyrld_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] action;
  logic [7:0] rx_char;
  modport source (output valid, action, rx_char, input ready);
  modport sink (input valid, action, rx_char, output ready);
  modport monitor (input valid, action, rx_char, ready);
endinterface

interface ttyrld_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] echo_char;
  logic       echo_valid;
  logic       last;
  logic [1:0] event_res;
  logic       overflow;
  logic [1:0] flow_request;
  logic       remote_stopped;
  logic       data_ready;
  logic [7:0] read_data;
  logic       read_valid;
  logic [9:0] fill_level;
  modport source (output valid, echo_char, echo_valid, last, event_res, overflow,
                  flow_request, remote_stopped, data_ready, read_data, read_valid,
                  fill_level, input ready);
  modport sink (input valid, echo_char, echo_valid, last, event_res, overflow,
                flow_request, remote_stopped, data_ready, read_data, read_valid,
                fill_level, output ready);
  modport monitor (input valid, echo_char, echo_valid, last, event_res, overflow,
                   flow_request, remote_stopped, data_ready, read_data, read_valid,
                   fill_level, ready);
endinterface

@@ rtl/core/ttyrld_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module ttyrld_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 512
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

@@ rtl/core/ttyrld_fifo.sv @@
// Short queue of classified items between the front and back parts.
module ttyrld_fifo (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    push,
  input  ttyrld_pkg::job_t        push_data,
  input  logic                    pop,
  output logic                    not_empty,
  output ttyrld_pkg::job_t        head,
  output logic [ttyrld_pkg::Q_CW-1:0] free_cnt
);
  import ttyrld_pkg::*;

  job_t            mem_r [Q_DEPTH];
  logic [Q_AW-1:0] wp_r, rp_r;
  logic [Q_CW-1:0] cnt_r;

  assign not_empty = (cnt_r != '0);
  assign head      = mem_r[rp_r];
  assign free_cnt  = Q_CW'(Q_DEPTH) - cnt_r;

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= push_data;
    end
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wp_r <= wp_r + 1'b1;
      if (pop)  rp_r <= rp_r + 1'b1;
      cnt_r <= cnt_r + Q_CW'(push) - Q_CW'(pop);
    end
  end
endmodule

@@ rtl/core/ttyrld_front.sv @@
// Front part: configuration, ring state update and classification of each item.
`include "tty_receive_line_discipline_defines.svh"
module ttyrld_front #(
  parameter int RING_DEPTH = 512
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_we,
  input  logic [2:0]                  cfg_idx,
  input  logic [9:0]                  cfg_wdata,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [1:0]                  in_action,
  input  logic [7:0]                  in_rx_char,
  input  logic [ttyrld_pkg::Q_CW-1:0] q_free,
  output logic                        q_push,
  output ttyrld_pkg::job_t            q_data
);
  import ttyrld_pkg::*;

  localparam int PW    = $clog2(RING_DEPTH);
  localparam int CW    = $clog2(RING_DEPTH + 1);
  localparam int SW    = ((CW > 10) ? CW : 10) + 2;
  localparam int NWRAP = 256 / RING_DEPTH + 1;
  localparam int AW    = ((PW > 9) ? PW : 9) + 1;

  logic [6:0] opt_r;
  logic [7:0] abort_r, erase_r, kill_r, eof_r, trap_r;
  logic [9:0] stop_r, resume_r;

  logic [PW-1:0] put_r, get_r, put_nxt, get_nxt;
  logic [CW-1:0] used_r, used_nxt;
  logic [7:0]    ll_r, ll_nxt;
  logic          lstop_r, lstop_nxt, rstop_r, rstop_nxt;

  // A line committed by a written byte needs a second RAM write for its length byte.
  logic          pend_r, pend_nxt;
  logic [PW-1:0] pend_addr_r, pend_addr_nxt;
  logic [7:0]    pend_data_r, pend_data_nxt;

  logic          stv_r, st_rd_r;
  job_t          st_job_r, job;

  logic          we;
  logic [PW-1:0] waddr;
  logic [7:0]    wdata, ram_q;
  logic          accept;

  function automatic logic [PW-1:0] wrap(input logic [AW-1:0] s);
    logic [AW-1:0] v;
    v = s;
    for (int i = 0; i < NWRAP; i++) begin
      if (v >= AW'(RING_DEPTH)) v = v - AW'(RING_DEPTH);
    end
    return v[PW-1:0];
  endfunction

  assign in_ready = !pend_r && (q_free > Q_CW'(stv_r));
  assign accept   = in_valid && in_ready;

  ttyrld_ram #(.WIDTH(8), .DEPTH(RING_DEPTH)) u_ram (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(get_r), .rdata(ram_q)
  );

  always_comb begin
    logic [7:0]        c;
    logic              line, ready, ovf, do_flow, wr_c;
    logic [CW-1:0]     fr;
    logic [8:0]        lenp1;
    logic signed [SW-1:0] f;
    logic [PW-1:0]     c_addr;

    put_nxt = put_r; get_nxt = get_r; used_nxt = used_r; ll_nxt = ll_r;
    lstop_nxt = lstop_r; rstop_nxt = rstop_r;
    pend_nxt = 1'b0; pend_addr_nxt = pend_addr_r; pend_data_nxt = pend_data_r;
    job = '0;
    c = in_rx_char; line = opt_r[OB_LINE]; ready = 1'b0; ovf = 1'b0;
    do_flow = 1'b0; wr_c = 1'b0; fr = '0; lenp1 = '0; f = '0; c_addr = put_r;
    we = pend_r; waddr = pend_addr_r; wdata = pend_data_r;

    if (accept) begin
      case (in_action)
        ACT_RECV: begin
          if (opt_r[OB_SEVEN]) c = c & MASK7;
          if (opt_r[OB_BREAK] && c == abort_r) begin
            job.event_res = EV_ABORT;
          end else if (opt_r[OB_MONTRAP] && c == trap_r) begin
            job.event_res = EV_TRAP;
          end else if (opt_r[OB_FLOW] && (c == CH_XOFF || c == CH_XON)) begin
            rstop_nxt = (c == CH_XOFF);
          end else begin
            if (opt_r[OB_CRMAP] && c == CH_CR) c = CH_LF;
            if (opt_r[OB_ECHO]) begin
              if (!line) begin
                job.echo[0] = c; job.necho = 2'd1;
              end else if (c == kill_r) begin
                job.echo[0] = CH_LF; job.necho = 2'd1;
              end else if (c == erase_r) begin
                if (ll_r != '0) begin
                  job.echo[0] = CH_BS; job.echo[1] = CH_SPACE; job.echo[2] = CH_BS;
                  job.necho = 2'd3;
                end
              end else if (c < CH_SPACE && c != CH_LF) begin
                job.echo[0] = CH_CARET; job.echo[1] = c + CH_AT; job.necho = 2'd2;
              end else begin
                job.echo[0] = c; job.necho = 2'd1;
              end
            end
            if (!line) begin
              if (used_r < CW'(RING_DEPTH)) begin
                we = 1'b1; waddr = put_r; wdata = c;
                put_nxt = wrap(AW'(put_r) + AW'(1));
                used_nxt = used_r + 1'b1;
                ready = (used_r == '0);
              end else begin
                ovf = 1'b1;
              end
            end else begin
              fr = CW'(RING_DEPTH) - used_r;
              if (c == erase_r) begin
                if (ll_r != '0) ll_nxt = ll_r - 1'b1;
              end else if (c == kill_r) begin
                ll_nxt = '0;
              end else if (c == eof_r) begin
                ready = (fr != '0);
              end else if (fr >= CW'(2)) begin
                if (SW'(fr) >= SW'(ll_r) + SW'(2)) ll_nxt = ll_r + 1'b1;
                else ovf = 1'b1;
                wr_c = 1'b1;
                c_addr = wrap(AW'(put_r) + AW'(ll_nxt));
                ready = (c == CH_LF) || (ll_nxt == LINE_MAX);
              end else begin
                ovf = 1'b1;
              end
              if (wr_c) begin
                we = 1'b1; waddr = c_addr; wdata = c;
              end
              if (ready) begin
                lenp1 = 9'(ll_nxt) + 9'd1;
                if (wr_c) begin
                  pend_nxt = 1'b1; pend_addr_nxt = put_r; pend_data_nxt = ll_nxt;
                end else begin
                  we = 1'b1; waddr = put_r; wdata = ll_nxt;
                end
                if ((SW'(used_r) + SW'(lenp1)) > SW'(RING_DEPTH)) used_nxt = CW'(RING_DEPTH);
                else used_nxt = CW'(SW'(used_r) + SW'(lenp1));
                put_nxt = wrap(AW'(put_r) + AW'(lenp1));
                ll_nxt = '0;
              end
            end
            do_flow = opt_r[OB_FLOW];
          end
        end
        ACT_POP: begin
          if (used_r != '0) begin
            job.read_valid = 1'b1;
            get_nxt = wrap(AW'(get_r) + AW'(1));
            used_nxt = used_r - 1'b1;
          end
          do_flow = opt_r[OB_FLOW] && lstop_r;
        end
        ACT_FLUSH: begin
          put_nxt = '0; get_nxt = '0; used_nxt = '0; ll_nxt = '0;
          if (lstop_r) begin
            lstop_nxt = 1'b0; job.flow_request = FLOW_XON;
          end
        end
        default: begin
        end
      endcase

      f = SW'(RING_DEPTH) - SW'(used_nxt);
      if (line) f = f - SW'(ll_nxt) - SW'(1);
      if (do_flow) begin
        if (!lstop_r) begin
          if (f < signed'(SW'(stop_r))) begin
            lstop_nxt = 1'b1; job.flow_request = FLOW_XOFF;
          end
        end else if (f > signed'(SW'(resume_r))) begin
          lstop_nxt = 1'b0; job.flow_request = FLOW_XON;
        end
      end
      job.overflow       = ovf;
      job.data_ready     = ready;
      job.remote_stopped = rstop_nxt;
      job.fill_level     = 10'(used_nxt);
    end
  end

  assign q_push = stv_r;
  always_comb begin
    q_data = st_job_r;
    q_data.read_data = st_rd_r ? ram_q : 8'h00;
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      st_job_r <= job;
      st_rd_r  <= job.read_valid;
    end
    pend_addr_r <= pend_addr_nxt;
    pend_data_r <= pend_data_nxt;
    if (!rst_n) begin
      opt_r <= '0; abort_r <= 8'd3; erase_r <= 8'd8; kill_r <= 8'd21;
      eof_r <= 8'd4; trap_r <= 8'd24; stop_r <= 10'd80; resume_r <= 10'd100;
      put_r <= '0; get_r <= '0; used_r <= '0; ll_r <= '0;
      lstop_r <= 1'b0; rstop_r <= 1'b0; pend_r <= 1'b0; stv_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_idx)
          REG_OPTION: opt_r    <= cfg_wdata[6:0];
          REG_ABORT:  abort_r  <= cfg_wdata[7:0];
          REG_ERASE:  erase_r  <= cfg_wdata[7:0];
          REG_KILL:   kill_r   <= cfg_wdata[7:0];
          REG_EOF:    eof_r    <= cfg_wdata[7:0];
          REG_TRAP:   trap_r   <= cfg_wdata[7:0];
          REG_STOP:   stop_r   <= cfg_wdata;
          REG_RESUME: resume_r <= cfg_wdata;
          default: begin
          end
        endcase
      end
      put_r <= put_nxt; get_r <= get_nxt; used_r <= used_nxt; ll_r <= ll_nxt;
      lstop_r <= lstop_nxt; rstop_r <= rstop_nxt;
      pend_r <= pend_nxt;
      stv_r  <= accept;
    end
  end

  `TTYRLD_ASSERT_NOW(a_fill_bound, 1'b1, used_r <= CW'(RING_DEPTH), "ring fill above depth")
  `TTYRLD_ASSERT_NEXT(a_pend_once, pend_r, !pend_r, "length write pending twice")
  `TTYRLD_ASSERT_NOW(a_push_room, stv_r, q_free != '0, "push into a full queue")
endmodule

@@ rtl/core/ttyrld_back.sv @@
// Back part: expands each queued item into one to three result items.
module ttyrld_back (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             q_not_empty,
  input  ttyrld_pkg::job_t q_head,
  output logic             q_pop,
  ttyrld_out_if.source     out_ch
);
  import ttyrld_pkg::*;

  logic [1:0] k_r, nres;
  logic       is_last;

  assign nres    = (q_head.necho == 2'd0) ? 2'd1 : q_head.necho;
  assign is_last = (k_r == nres - 2'd1);
  assign q_pop   = q_not_empty && out_ch.ready && is_last;

  assign out_ch.valid          = q_not_empty;
  assign out_ch.echo_char      = (k_r < q_head.necho) ? q_head.echo[k_r] : 8'h00;
  assign out_ch.echo_valid     = (k_r < q_head.necho);
  assign out_ch.last           = is_last;
  assign out_ch.event_res      = q_head.event_res;
  assign out_ch.overflow       = q_head.overflow;
  assign out_ch.flow_request   = q_head.flow_request;
  assign out_ch.remote_stopped = q_head.remote_stopped;
  assign out_ch.data_ready     = q_head.data_ready;
  assign out_ch.read_data      = q_head.read_data;
  assign out_ch.read_valid     = q_head.read_valid;
  assign out_ch.fill_level     = q_head.fill_level;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      k_r <= '0;
    end else if (q_not_empty && out_ch.ready) begin
      k_r <= is_last ? 2'd0 : k_r + 2'd1;
    end
  end
endmodule

@@ rtl/core/tty_receive_line_discipline.sv @@
// Top level: receive line discipline of a serial terminal with XON/XOFF flow control.
// An accepted item is registered in the front part, then written into the queue whose head drives the results.
// Throughput: one item per cycle while the queue has room and no length write is pending; results leave one per
// cycle while out_ch.ready is high. A newline or 255th byte that commits a line needs a second RAM write for length.
// Reset: synchronous active-low rst_n clears pointers, counts and flags and restores the
// register defaults; ring contents are left as they are.
module tty_receive_line_discipline #(
  parameter int RING_DEPTH = 512
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         cfg_we,
  input  logic [2:0]   cfg_idx,
  input  logic [9:0]   cfg_wdata,
  ttyrld_in_if.sink    in_ch,
  ttyrld_out_if.source out_ch
);
  import ttyrld_pkg::*;

  // The front part owns the configuration and all ring state: it decides
  // each item completely in the cycle it is accepted, and a pop reads the
  // ring RAM so the classified item enters the queue in the next cycle.
  logic            q_push, q_pop, q_not_empty;
  job_t            q_data, q_head;
  logic [Q_CW-1:0] q_free;

  ttyrld_front #(.RING_DEPTH(RING_DEPTH)) u_front (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_wdata(cfg_wdata),
    .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .in_action(in_ch.action), .in_rx_char(in_ch.rx_char),
    .q_free(q_free), .q_push(q_push), .q_data(q_data)
  );

  // The queue lets the front keep taking items while results wait downstream.
  ttyrld_fifo u_fifo (
    .clk(clk), .rst_n(rst_n),
    .push(q_push), .push_data(q_data), .pop(q_pop),
    .not_empty(q_not_empty), .head(q_head), .free_cnt(q_free)
  );

  // The back part walks the echo bytes of the head item, one result per cycle while out_ch.ready is high.
  ttyrld_back u_back (
    .clk(clk), .rst_n(rst_n),
    .q_not_empty(q_not_empty), .q_head(q_head), .q_pop(q_pop),
    .out_ch(out_ch)
  );
endmodule
